/* src/bacd_pkg.sv */
// shared types and constants for the block average change detector
`timescale 1ns / 1ps

package bacd_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_FRAME_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_BLOCK_WIDTH   = 3'd1;
  localparam logic [2:0] CFG_BLOCK_HEIGHT  = 3'd2;
  localparam logic [2:0] CFG_BLOCKS_ACROSS = 3'd3;
  localparam logic [2:0] CFG_BLOCKS_DOWN   = 3'd4;
  localparam logic [2:0] CFG_THRESHOLD     = 3'd5;

  // register reset values
  localparam logic [10:0] RST_FRAME_WIDTH   = 11'd320;
  localparam logic [5:0]  RST_BLOCK_WIDTH   = 6'd6;
  localparam logic [5:0]  RST_BLOCK_HEIGHT  = 6'd6;
  localparam logic [6:0]  RST_BLOCKS_ACROSS = 7'd50;
  localparam logic [6:0]  RST_BLOCKS_DOWN   = 7'd31;
  localparam logic [7:0]  RST_THRESHOLD     = 8'd15;

  // register limits
  localparam logic [10:0] MAX_FRAME_WIDTH   = 11'd1024;
  localparam logic [5:0]  MAX_BLOCK_SIDE    = 6'd32;
  localparam logic [6:0]  MAX_BLOCKS_ACROSS = 7'd64;
  localparam logic [6:0]  MAX_BLOCKS_DOWN   = 7'd64;

  // pixel row counter saturates here
  localparam logic [10:0] ROW_LIMIT = 11'd2047;

  // floor(x/3) for x <= 765 is (x*683) >> 11
  localparam logic [9:0] GRAY_RECIP = 10'd683;

  // one quotient bit per divider step
  localparam logic [4:0] DIV_STEPS = 5'd18;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic accept;
    logic div_col_start;
    logic div_row_start;
    logic div_lvl_start;
    logic load_col;
    logic load_row;
    logic load_lvl;
    logic read;
    logic sum;
    logic advance;
    logic commit;
    logic clear;
  } cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic resync;
    logic div_done;
    logic in_grid;
    logic block_last;
    logic change;
    logic out_free;
    logic clear_done;
  } status_t;

endpackage

/* src/bacd_divider.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module bacd_divider import bacd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [17:0] dividend,
  input  logic [10:0] divisor,
  output logic [17:0] quotient,
  output logic [10:0] remainder,
  output logic        done
);

  logic        busy;
  logic [4:0]  cnt;
  logic [17:0] quo;
  logic [10:0] rem;
  logic [10:0] dvs;
  logic [11:0] trial;
  logic        fits;

  // one trial subtraction per step
  always_comb begin
    trial = {rem, quo[17]};
    fits  = (trial >= {1'b0, dvs});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[16:0], fits};
      rem <= fits ? 11'(trial - {1'b0, dvs}) : trial[10:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

/* src/bacd_datapath.sv */
// configuration, position counters, block sums, level store and result register
`timescale 1ns / 1ps

module bacd_datapath import bacd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        frame_start,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        m_ready,
  output logic        m_valid,
  output logic [31:0] m_data
);

  // configuration registers
  logic [10:0] frame_width;
  logic [5:0]  block_width;
  logic [5:0]  block_height;
  logic [6:0]  blocks_across;
  logic [6:0]  blocks_down;
  logic [7:0]  change_threshold;

  // clamped configuration
  logic [10:0] fw_c;
  logic [5:0]  bw_c;
  logic [5:0]  bh_c;
  logic [6:0]  ba_c;
  logic [6:0]  bd_c;
  logic [10:0] area;

  // position state
  logic [9:0]  pixel_column;
  logic [10:0] pixel_row;
  logic [9:0]  bx;
  logic [10:0] by;
  logic [4:0]  col_in_block;
  logic [4:0]  row_in_block;
  logic        stale;

  // per item payload
  logic [9:0]  sum3;
  logic [19:0] gray_prod;
  logic [7:0]  gray;
  logic [17:0] sum_q;
  logic [17:0] sum_new;
  logic [7:0]  level_q;
  logic [7:0]  diff;
  logic [10:0] col_inc;

  // memories
  logic [17:0] column_sums [64];
  logic [7:0]  block_levels [4096];
  logic [17:0] cs_rd;
  logic [7:0]  lv_rd;
  logic [11:0] lv_addr;
  logic [11:0] clr_addr;

  // divider
  logic        div_start;
  logic [17:0] div_dividend;
  logic [10:0] div_divisor;
  logic [17:0] div_quo;
  logic [10:0] div_rem;
  logic        div_done;

  // result register
  logic [5:0]  block_column;
  logic [5:0]  block_row;
  logic [7:0]  new_level;
  logic [7:0]  change_amount;

  logic        advance_en;
  logic        change;
  logic        in_grid;

  // clamp registers to their legal ranges
  always_comb begin
    fw_c = (frame_width == '0) ? 11'd1 :
           (frame_width > MAX_FRAME_WIDTH) ? MAX_FRAME_WIDTH : frame_width;
    bw_c = (block_width == '0) ? 6'd1 :
           (block_width > MAX_BLOCK_SIDE) ? MAX_BLOCK_SIDE : block_width;
    bh_c = (block_height == '0) ? 6'd1 :
           (block_height > MAX_BLOCK_SIDE) ? MAX_BLOCK_SIDE : block_height;
    ba_c = (blocks_across > MAX_BLOCKS_ACROSS) ? MAX_BLOCKS_ACROSS : blocks_across;
    bd_c = (blocks_down > MAX_BLOCKS_DOWN) ? MAX_BLOCKS_DOWN : blocks_down;
    area = 11'({5'd0, bw_c} * {5'd0, bh_c});
  end

  // block geometry flags
  always_comb begin
    in_grid = (bx < {3'd0, ba_c}) && (by < {4'd0, bd_c});
    lv_addr = {by[5:0], bx[5:0]};
    col_inc = {1'b0, pixel_column} + 11'd1;
    advance_en = cmd.advance | cmd.commit;
  end

  // gray value and running block sum
  always_comb begin
    gray_prod = {10'd0, sum3} * {10'd0, GRAY_RECIP};
    if (col_in_block == '0 && row_in_block == '0) begin
      sum_new = {10'd0, gray};
    end else begin
      sum_new = cs_rd + {10'd0, gray};
    end
  end

  // level difference against the stored level
  always_comb begin
    diff   = (level_q > lv_rd) ? (level_q - lv_rd) : (lv_rd - level_q);
    change = (diff > change_threshold);
  end

  // divider operand select
  always_comb begin
    div_start    = cmd.div_col_start | cmd.div_row_start | cmd.div_lvl_start;
    div_dividend = sum_q;
    div_divisor  = area;
    if (cmd.div_col_start) begin
      div_dividend = {8'd0, pixel_column};
      div_divisor  = {5'd0, bw_c};
    end else if (cmd.div_row_start) begin
      div_dividend = {7'd0, pixel_row};
      div_divisor  = {5'd0, bh_c};
    end
  end

  bacd_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= RST_FRAME_WIDTH;
      block_width      <= RST_BLOCK_WIDTH;
      block_height     <= RST_BLOCK_HEIGHT;
      blocks_across    <= RST_BLOCKS_ACROSS;
      blocks_down      <= RST_BLOCKS_DOWN;
      change_threshold <= RST_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:   frame_width      <= cfg_data;
        CFG_BLOCK_WIDTH:   block_width      <= cfg_data[5:0];
        CFG_BLOCK_HEIGHT:  block_height     <= cfg_data[5:0];
        CFG_BLOCKS_ACROSS: blocks_across    <= cfg_data[6:0];
        CFG_BLOCKS_DOWN:   blocks_down      <= cfg_data[6:0];
        CFG_THRESHOLD:     change_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // position counters, block coordinates kept in step with the pixel position
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column <= '0;
      pixel_row    <= '0;
      bx           <= '0;
      by           <= '0;
      col_in_block <= '0;
      row_in_block <= '0;
      stale        <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (frame_start) begin
          pixel_column <= '0;
          pixel_row    <= '0;
          bx           <= '0;
          by           <= '0;
          col_in_block <= '0;
          row_in_block <= '0;
          stale        <= 1'b0;
        end else if ({1'b0, pixel_column} >= fw_c) begin
          pixel_column <= '0;
          if (pixel_row < ROW_LIMIT) begin
            pixel_row <= pixel_row + 11'd1;
          end
        end
      end
      if (cmd.load_col) begin
        bx           <= div_quo[9:0];
        col_in_block <= div_rem[4:0];
      end
      if (cmd.load_row) begin
        by           <= div_quo[10:0];
        row_in_block <= div_rem[4:0];
        stale        <= 1'b0;
      end
      if (advance_en) begin
        if (col_inc >= fw_c) begin
          pixel_column <= '0;
          bx           <= '0;
          col_in_block <= '0;
          if (pixel_row < ROW_LIMIT) begin
            pixel_row <= pixel_row + 11'd1;
            if ({1'b0, row_in_block} == bh_c - 6'd1) begin
              row_in_block <= '0;
              by           <= by + 11'd1;
            end else begin
              row_in_block <= row_in_block + 5'd1;
            end
          end
        end else begin
          pixel_column <= col_inc[9:0];
          if ({1'b0, col_in_block} == bw_c - 6'd1) begin
            col_in_block <= '0;
            bx           <= bx + 10'd1;
          end else begin
            col_in_block <= col_in_block + 5'd1;
          end
        end
      end
      // a geometry change invalidates the block coordinates
      if (cfg_we && (cfg_index inside {CFG_FRAME_WIDTH, CFG_BLOCK_WIDTH,
                                       CFG_BLOCK_HEIGHT})) begin
        stale <= 1'b1;
      end
    end
  end

  // pixel payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum3 <= {2'd0, red} + {2'd0, green} + {2'd0, blue};
    end
    if (cmd.read) begin
      gray <= gray_prod[18:11];
    end
    if (cmd.sum) begin
      sum_q <= sum_new;
    end
    if (cmd.load_lvl) begin
      level_q <= (div_quo[17:8] != '0) ? 8'hFF : div_quo[7:0];
    end
  end

  // column sum memory
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      cs_rd <= column_sums[bx[5:0]];
    end
    if (cmd.sum && in_grid) begin
      column_sums[bx[5:0]] <= sum_new;
    end
  end

  // level store memory
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      lv_rd <= block_levels[lv_addr];
    end
    if (cmd.clear) begin
      block_levels[clr_addr] <= '0;
    end else if (cmd.commit && change) begin
      block_levels[lv_addr] <= level_q;
    end
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 12'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.commit && change) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && change) begin
      block_column  <= bx[5:0];
      block_row     <= by[5:0];
      new_level     <= level_q;
      change_amount <= diff;
    end
  end

  assign m_data = {4'd0, change_amount, new_level, block_row, block_column};

  // status back to the sequencer
  always_comb begin
    status.resync     = stale & ~frame_start;
    status.div_done   = div_done;
    status.in_grid    = in_grid;
    status.block_last = ({1'b0, col_in_block} == bw_c - 6'd1) &&
                        ({1'b0, row_in_block} == bh_c - 6'd1);
    status.change     = change;
    status.out_free   = ~m_valid | m_ready;
    status.clear_done = (clr_addr == 12'hFFF);
  end

endmodule

/* src/bacd_ctrl.sv */
// sequencer for one pixel transfer at a time
`timescale 1ns / 1ps

module bacd_ctrl import bacd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_valid,
  output logic    s_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [10:0] {
    ST_CLEAR    = 11'b000_0000_0001,
    ST_IDLE     = 11'b000_0000_0010,
    ST_COL_GO   = 11'b000_0000_0100,
    ST_COL_WAIT = 11'b000_0000_1000,
    ST_ROW_GO   = 11'b000_0001_0000,
    ST_ROW_WAIT = 11'b000_0010_0000,
    ST_READ     = 11'b000_0100_0000,
    ST_SUM      = 11'b000_1000_0000,
    ST_LVL_GO   = 11'b001_0000_0000,
    ST_LVL_WAIT = 11'b010_0000_0000,
    ST_CMP      = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_ready    = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          cmd.accept = 1'b1;
          state_next = status.resync ? ST_COL_GO : ST_READ;
        end
      end
      ST_COL_GO: begin
        cmd.div_col_start = 1'b1;
        state_next        = ST_COL_WAIT;
      end
      ST_COL_WAIT: begin
        if (status.div_done) begin
          cmd.load_col = 1'b1;
          state_next   = ST_ROW_GO;
        end
      end
      ST_ROW_GO: begin
        cmd.div_row_start = 1'b1;
        state_next        = ST_ROW_WAIT;
      end
      ST_ROW_WAIT: begin
        if (status.div_done) begin
          cmd.load_row = 1'b1;
          state_next   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        if (status.in_grid && status.block_last) begin
          state_next = ST_LVL_GO;
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_LVL_GO: begin
        cmd.div_lvl_start = 1'b1;
        state_next        = ST_LVL_WAIT;
      end
      ST_LVL_WAIT: begin
        if (status.div_done) begin
          cmd.load_lvl = 1'b1;
          state_next   = ST_CMP;
        end
      end
      ST_CMP: begin
        // hold while a changed block waits for the result register
        if (!status.change || status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/block_average_change_detector.sv */
// a pixel is taken in ST_IDLE and passes ST_READ and ST_SUM; a block's last pixel then
//   passes ST_LVL_GO, ST_LVL_WAIT and ST_CMP, where a changed block waits for the result
//   register before its report shows on the master side; one pixel is handled at a time
// the first pixel after a write of frame_width, block_width or block_height first passes two
//   divisions unless it marks a frame start; the 18-step shared divider does all divisions
// reset: synchronous; then all 4096 level store entries are cleared, no pixel taken
`timescale 1ns / 1ps

module block_average_change_detector import bacd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  // pixel stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic        s_axis_tuser,   // frame_start
  // changed block stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // block_column[5:0], block_row[11:6],
                                      // new_level[19:12], change_amount[27:20]
);

  cmd_t    cmd;
  status_t status;

  bacd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  bacd_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .red         (s_axis_tdata[7:0]),
    .green       (s_axis_tdata[15:8]),
    .blue        (s_axis_tdata[23:16]),
    .frame_start (s_axis_tuser),
    .cmd         (cmd),
    .status      (status),
    .m_ready     (m_axis_tready),
    .m_valid     (m_axis_tvalid),
    .m_data      (m_axis_tdata)
  );

endmodule

/* verif/bacd_report_checker.sv */
// watches the pixel and report streams, predicts every changed-block report and compares
`timescale 1ns / 1ps

module bacd_report_checker import bacd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic        s_axis_tuser,   // frame_start
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // block_column[5:0], block_row[11:6],
                                      // new_level[19:12], change_amount[27:20]
  output int          mismatches,
  output int          reports_waiting,
  output int          reports_checked
);

  // one report as it sits in the low bits of tdata
  typedef struct packed {
    logic [7:0] change_amount;
    logic [7:0] new_level;
    logic [5:0] block_row;
    logic [5:0] block_column;
  } block_report_t;

  // shadow copy of the registers
  logic [10:0] cfg_frame_width;
  logic [5:0]  cfg_block_width;
  logic [5:0]  cfg_block_height;
  logic [6:0]  cfg_blocks_across;
  logic [6:0]  cfg_blocks_down;
  logic [7:0]  cfg_threshold;

  // shadow copy of the datapath state
  logic [17:0]   partial_sum [MAX_BLOCKS_ACROSS];
  logic [7:0]    stored_level [int'(MAX_BLOCKS_ACROSS) * int'(MAX_BLOCKS_DOWN)];
  int unsigned   pix_col;
  int unsigned   pix_row;

  block_report_t expected_reports [$];
  int            error_total;
  int            checked_total;

  function automatic int unsigned bounded(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // walk one pixel through the grid and queue a report when its block changed enough
  function automatic void predict_block_report(logic [7:0] red, logic [7:0] green,
                                               logic [7:0] blue, logic frame_start);
    int unsigned   fw, bw, bh, ba, bd;
    int unsigned   gray, bx, by, col_in, row_in, lvl, prev, diff, idx;
    logic [17:0]   acc;
    block_report_t rep;
    fw = bounded(cfg_frame_width, 1, MAX_FRAME_WIDTH);
    bw = bounded(cfg_block_width, 1, MAX_BLOCK_SIDE);
    bh = bounded(cfg_block_height, 1, MAX_BLOCK_SIDE);
    ba = bounded(cfg_blocks_across, 0, MAX_BLOCKS_ACROSS);
    bd = bounded(cfg_blocks_down, 0, MAX_BLOCKS_DOWN);

    if (frame_start) begin
      pix_col = 0;
      pix_row = 0;
    end
    // a narrowed line pushes the position onto the next row
    if (pix_col >= fw) begin
      pix_col = 0;
      if (pix_row < ROW_LIMIT) pix_row++;
    end

    gray   = (32'(red) + 32'(green) + 32'(blue)) / 3;
    bx     = pix_col / bw;
    by     = pix_row / bh;
    col_in = pix_col % bw;
    row_in = pix_row % bh;

    if (bx < ba && by < bd) begin
      // the top-left pixel of a block restarts its sum
      if (col_in == 0 && row_in == 0) acc = 18'(gray);
      else acc = partial_sum[bx] + 18'(gray);
      partial_sum[bx] = acc;

      if (col_in == bw - 1 && row_in == bh - 1) begin
        lvl = 32'(acc) / (bw * bh);
        if (lvl > 255) lvl = 255;
        idx  = by * MAX_BLOCKS_ACROSS + bx;
        prev = stored_level[idx];
        diff = (lvl > prev) ? lvl - prev : prev - lvl;
        if (diff > cfg_threshold) begin
          stored_level[idx]  = 8'(lvl);
          rep.block_column   = 6'(bx);
          rep.block_row      = 6'(by);
          rep.new_level      = 8'(lvl);
          rep.change_amount  = 8'(diff);
          expected_reports.push_back(rep);
        end
      end
    end

    pix_col++;
    if (pix_col >= fw) begin
      pix_col = 0;
      if (pix_row < ROW_LIMIT) pix_row++;
    end
  endfunction

  // compare one report transfer against the oldest prediction
  function automatic void check_report(logic [31:0] data);
    block_report_t got, want;
    got = data[27:0];
    checked_total++;
    if (expected_reports.size() == 0) begin
      error_total++;
      if (error_total <= 10)
        $display("%0t: report with nothing predicted: col %0d row %0d level %0d change %0d",
                 $time, got.block_column, got.block_row, got.new_level, got.change_amount);
      return;
    end
    want = expected_reports.pop_front();
    if (got.block_column != want.block_column || got.block_row != want.block_row ||
        got.new_level != want.new_level || got.change_amount != want.change_amount) begin
      error_total++;
      if (error_total <= 10)
        $display("%0t: report mismatch: expected col %0d row %0d level %0d change %0d, %s",
                 $time, want.block_column, want.block_row, want.new_level,
                 want.change_amount,
                 $sformatf("got col %0d row %0d level %0d change %0d", got.block_column,
                           got.block_row, got.new_level, got.change_amount));
    end
  endfunction

  // sample both channels and the register port at each edge
  always @(posedge clk) begin
    if (rst) begin
      cfg_frame_width   = RST_FRAME_WIDTH;
      cfg_block_width   = RST_BLOCK_WIDTH;
      cfg_block_height  = RST_BLOCK_HEIGHT;
      cfg_blocks_across = RST_BLOCKS_ACROSS;
      cfg_blocks_down   = RST_BLOCKS_DOWN;
      cfg_threshold     = RST_THRESHOLD;
      foreach (partial_sum[i]) partial_sum[i] = '0;
      foreach (stored_level[i]) stored_level[i] = '0;
      pix_col = 0;
      pix_row = 0;
      expected_reports.delete();
      error_total   = 0;
      checked_total = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:   cfg_frame_width   = cfg_data;
          CFG_BLOCK_WIDTH:   cfg_block_width   = cfg_data[5:0];
          CFG_BLOCK_HEIGHT:  cfg_block_height  = cfg_data[5:0];
          CFG_BLOCKS_ACROSS: cfg_blocks_across = cfg_data[6:0];
          CFG_BLOCKS_DOWN:   cfg_blocks_down   = cfg_data[6:0];
          CFG_THRESHOLD:     cfg_threshold     = cfg_data[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_block_report(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                             s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) check_report(m_axis_tdata);
    end
    mismatches      <= error_total;
    reports_waiting <= expected_reports.size();
    reports_checked <= checked_total;
  end

endmodule

/* verif/tb_block_average_change_detector.sv */
// pixel stimulus, receiver back-pressure and verdict for the block average change detector
`timescale 1ns / 1ps

module tb_block_average_change_detector import bacd_pkg::*;;

  localparam int unsigned SETTLE_CYCLES = 80;      // block end plus two resync divisions
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned LONG_HOLD     = 600;

  typedef enum logic [1:0] {RX_STEADY, RX_BUSY, RX_SPARSE} rx_mode_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [10:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // red[7:0], green[15:8], blue[23:16]
  logic        s_axis_tuser;   // frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // block_column[5:0], block_row[11:6],
                               // new_level[19:12], change_amount[27:20]

  int          mismatches;
  int          reports_waiting;
  int          reports_checked;

  bit          hold_request = 1'b0;
  int unsigned burst_left   = 0;
  int unsigned gap_limit    = 20;
  int unsigned pixels_sent  = 0;
  int unsigned settings_used = 0;

  block_average_change_detector dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bacd_report_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .mismatches      (mismatches),
    .reports_waiting (reports_waiting),
    .reports_checked (reports_checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stall pattern, plus one long hold-off on request
  initial begin : receiver
    rx_mode_t    mode;
    int unsigned left;
    bit          hold_done;
    mode      = RX_STEADY;
    left      = 0;
    hold_done = 1'b0;
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 2));
        left = $urandom_range(1, 64);
      end
      left--;
      case (mode)
        RX_STEADY: m_axis_tready <= 1'b1;
        RX_BUSY:   m_axis_tready <= ($urandom_range(0, 3) != 0);
        default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
      @(posedge clk);
    end
  end

  // one pixel transfer, opening a new burst when the last one ran out, mostly after a random gap
  task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input logic first);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_limit > 0 && $urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_limit)) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tdata  <= {blue, green, red};
    s_axis_tuser  <= first;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pixels_sent++;
  endtask

  // stop sending, wait for every predicted report or the drain limit, then for the block to go quiet
  task automatic settle();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    while (reports_waiting != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, with random junk above the register's width
  task automatic write_reg(input logic [2:0] index, input int unsigned value,
                           input int unsigned width);
    logic [10:0] junk;
    junk = ($urandom_range(0, 1) == 1) ? 11'($urandom << width) : 11'd0;
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= 11'(value) | junk;
    @(posedge clk);
  endtask

  task automatic write_config(input int unsigned fw, input int unsigned bw,
                              input int unsigned bh, input int unsigned ba,
                              input int unsigned bd, input int unsigned thr);
    write_reg(CFG_FRAME_WIDTH, fw, 11);
    write_reg(CFG_BLOCK_WIDTH, bw, 6);
    write_reg(CFG_BLOCK_HEIGHT, bh, 6);
    write_reg(CFG_BLOCKS_ACROSS, ba, 7);
    write_reg(CFG_BLOCKS_DOWN, bd, 7);
    write_reg(CFG_THRESHOLD, thr, 8);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] near(int base, int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    return (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : 8'(v));
  endfunction

  // reconfigure, then stream frames of one brightness each, some cut short or unmarked
  task automatic run_phase(input int unsigned fw, input int unsigned bw, input int unsigned bh,
                           input int unsigned ba, input int unsigned bd, input int unsigned thr,
                           input int unsigned count, input bit restart);
    int unsigned fw_eff, bh_eff, bd_eff, frame_len, pos;
    int          base, spread;
    bit          mark_start, force_start;
    logic [7:0]  red, green, blue;
    settle();
    write_config(fw, bw, bh, ba, bd, thr);
    fw_eff = (fw == 0) ? 1 : ((fw > MAX_FRAME_WIDTH) ? MAX_FRAME_WIDTH : fw);
    bh_eff = (bh == 0) ? 1 : ((bh > MAX_BLOCK_SIDE) ? MAX_BLOCK_SIDE : bh);
    bd_eff = (bd == 0) ? 1 : ((bd > MAX_BLOCKS_DOWN) ? MAX_BLOCKS_DOWN : bd);
    frame_len   = fw_eff * (bh_eff * bd_eff + $urandom_range(0, 2));
    pos         = restart ? 0 : 1;
    force_start = restart;
    base        = $urandom_range(0, 255);
    spread      = 40;
    mark_start  = 1'b0;
    repeat (count) begin
      if (pos == 0) begin
        base = $urandom_range(0, 255);
        case ($urandom_range(0, 3))
          0:       spread = 0;
          1:       spread = 6;
          2:       spread = 40;
          default: spread = 128;
        endcase
        mark_start  = force_start || ($urandom_range(0, 9) != 0);
        force_start = 1'b0;
        frame_len   = fw_eff * (bh_eff * bd_eff + $urandom_range(0, 2));
      end
      // mostly pixels near the frame's brightness, a few of pure noise
      if ($urandom_range(0, 19) == 0) begin
        red   = 8'($urandom);
        green = 8'($urandom);
        blue  = 8'($urandom);
      end else begin
        red   = near(base, spread);
        green = near(base, spread);
        blue  = near(base, spread);
      end
      send_pixel(red, green, blue, pos == 0 && mark_start);
      pos++;
      if (pos >= frame_len || $urandom_range(0, 49) == 0) pos = 0;
    end
  endtask

  // small grids that finish blocks often, with the odd register at an extreme
  task automatic random_phase();
    int unsigned fw, bw, bh, ba, bd, thr, pick;
    pick = $urandom_range(0, 9);
    fw = (pick < 8) ? $urandom_range(1, 12) :
         ((pick == 8) ? $urandom_range(0, 1) : $urandom_range(13, 100));
    bw = ($urandom_range(0, 9) == 0) ? MAX_BLOCK_SIDE : $urandom_range(1, 4);
    bh = $urandom_range(1, 3);
    ba = ($urandom_range(0, 9) == 0) ? MAX_BLOCKS_ACROSS : $urandom_range(1, 4);
    bd = $urandom_range(1, 4);
    pick = $urandom_range(0, 9);
    thr = (pick < 6) ? $urandom_range(0, 40) :
          ((pick == 6) ? 0 : ((pick == 7) ? 255 : $urandom_range(0, 255)));
    run_phase(fw, bw, bh, ba, bd, thr, $urandom_range(20, 45), $urandom_range(0, 9) < 7);
  endtask

  initial begin : stimulus
    logic [24:0] directed [21];   // {frame_start, blue, green, red}
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_FRAME_WIDTH;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one-pixel blocks: color extremes, walking bits, gray rounding, then a revisit
    directed = '{25'h1000000, 25'h0ffffff, 25'h00000ff, 25'h000ff00, 25'h0ff0000,
                 25'h0000101, 25'h0010101, 25'h0fffffe, 25'h0010101, 25'h0020202,
                 25'h0040404, 25'h0080808, 25'h0101010, 25'h0202020, 25'h0404040,
                 25'h0808080, 25'h0feffff, 25'h0204080, 25'h1000000, 25'h0ffffff,
                 25'h0000000};
    settle();
    write_config(64, 1, 1, 64, 64, 0);
    foreach (directed[i])
      send_pixel(directed[i][7:0], directed[i][15:8], directed[i][23:16], directed[i][24]);

    // one full row of one-pixel blocks from a frame start, so every column sum is written
    for (int i = 0; i < 64; i++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 0);

    // receiver holds off while the sender keeps pixels coming
    settle();
    gap_limit = 0;
    hold_request <= 1'b1;
    run_phase(64, 1, 1, 64, 64, 0, 100, 1'b0);
    gap_limit = 20;

    random_phase();
    random_phase();
    // zero frame and block widths, oversize block height
    run_phase(0, 0, 63, 1, 3, $urandom_range(0, 10), 60, 1'b1);
    random_phase();
    // oversize block width and grid height, zero block height
    run_phase(40, 63, 0, 2, 127, 3, 60, 1'b1);
    random_phase();
    // oversize grid width
    run_phase(80, 1, 1, 127, 2, 0, 40, 1'b1);
    // empty grids
    run_phase(8, 1, 1, 0, 8, 0, 20, 1'b1);
    run_phase(8, 1, 1, 8, 0, 0, 20, 1'b0);
    random_phase();
    // oversize frame width, clamped to the largest allowed width
    run_phase(2047, 16, 1, 64, 2, 4, 40, 1'b1);
    random_phase();
    // one-pixel lines: every block is a strip 32 rows tall
    run_phase(1, 1, 32, 1, 64, 8, 80, 1'b1);
    random_phase();
    random_phase();
    random_phase();
    random_phase();
    run_phase(1024, 32, 1, 64, 1, 255, 40, 1'b1);
    random_phase();

    settle();
    $display("covered %0d pixels under %0d register settings, %0d reports checked",
             pixels_sent, settings_used, reports_checked);
    $display("including clamped, zero and empty grids and register changes mid-frame");
    if (reports_waiting != 0)
      $display("%0d predicted reports never arrived", reports_waiting);
    if (mismatches == 0 && reports_waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
src/bacd_pkg.sv
src/bacd_divider.sv
src/bacd_datapath.sv
src/bacd_ctrl.sv
src/block_average_change_detector.sv
verif/bacd_report_checker.sv
verif/tb_block_average_change_detector.sv
